// ----- hw/rtl/fmqd_pkg.sv -----
// Shared types and constants of the FM quadrature discriminator.
// Used by the front end, the divider, the arctangent unit and the top level.
// No dependencies.
package fmqd_pkg;

  localparam int unsigned SampleW = 8;   // raw I or Q byte
  localparam int unsigned MapW    = 9;   // odd integer 2*b-255
  localparam int unsigned ProdW   = 18;  // dot and cross products
  localparam int unsigned MagW    = 17;  // magnitudes of dot and cross
  localparam int unsigned QuotW   = 17;  // Q0.16 ratio, 0..65536
  localparam int unsigned GainW   = 16;  // Q4.12 gain
  localparam int unsigned MpxW    = 16;  // Q3.12 output

  localparam logic [GainW-1:0] GainReset = 16'd2225;

  // Octant information that travels alongside the ratio.
  typedef struct packed {
    logic zero;   // both products are zero
    logic swap;   // |cross| > |dot|, ratio is dot/cross
    logic x_neg;  // dot < 0
    logic y_neg;  // cross < 0
    logic y_pos;  // cross > 0
  } fmqd_side_t;

endpackage

// ----- hw/rtl/fm_quadrature_discriminator.sv -----
// FM quadrature discriminator, top level.
// Depends on fmqd_pkg, fmqd_front, fmqd_div, fmqd_atan and fmqd_skid.
//
// Usage: raw unsigned I and Q bytes enter on the s_axis channel, one IQ pair
// per beat. For every input beat exactly one signed Q3.12 MPX sample leaves
// on the m_axis channel, in order. Each sample is the phase step against the
// previous pair, atan2(cross, dot), scaled by the Q4.12 gain register and
// saturated to 16 bits. The gain is written on the cfg channel, which is
// always ready; write it only while no beats are in flight.
// Throughput: one beat per cycle while the skid slot is empty. A beat passes
// three front-end stages, the 17 divider stages for the Q0.16 ratio, nine
// arctangent and gain stages and the output register on its way to m_axis.
// Reset clears all valid bits, sets the gain to 2225 and zeroes the stored
// previous pair, so the first result after reset is zero.
// When m_axis stalls, the beat in flight lands in a skid slot and the whole
// pipeline then holds; s_axis_tready drops for as long as that slot is full.
module fm_quadrature_discriminator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] i_sample, [15:8] q_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] mpx_sample
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i     // discriminator_gain, Q4.12
);
  import fmqd_pkg::*;

  logic              pipe_en;
  logic [GainW-1:0]  gain_q;
  logic              fr_valid, dv_valid, at_valid;
  logic [MagW-1:0]   fr_num, fr_den;
  fmqd_side_t        fr_side, dv_side;
  logic [QuotW-1:0]  dv_quot;
  logic signed [MpxW-1:0] at_mpx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  fmqd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (s_axis_tvalid),
    .i_sample_i  (s_axis_tdata[7:0]),
    .q_sample_i  (s_axis_tdata[15:8]),
    .out_valid_o (fr_valid),
    .num_o       (fr_num),
    .den_o       (fr_den),
    .side_o      (fr_side)
  );

  fmqd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (fr_valid),
    .num_i       (fr_num),
    .den_i       (fr_den),
    .side_i      (fr_side),
    .out_valid_o (dv_valid),
    .quot_o      (dv_quot),
    .side_o      (dv_side)
  );

  fmqd_atan u_atan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (dv_valid),
    .ratio_i     (dv_quot),
    .side_i      (dv_side),
    .gain_i      (gain_q),
    .out_valid_o (at_valid),
    .mpx_o       (at_mpx)
  );

  fmqd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (at_valid),
    .in_data_i   (at_mpx),
    .pipe_en_o   (pipe_en),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready)
    else $error("input reopened while the output stays stalled");

endmodule

// ----- hw/rtl/fmqd_front.sv -----
// Front end: byte mapping, previous-sample register, dot and cross products,
// and octant reduction into numerator, denominator and sign flags.
// Depends on fmqd_pkg.
module fmqd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [7:0]               i_sample_i,
  input  logic [7:0]               q_sample_i,
  output logic                     out_valid_o,
  output logic [16:0]              num_o,
  output logic [16:0]              den_o,
  output fmqd_pkg::fmqd_side_t     side_o
);
  import fmqd_pkg::*;

  logic signed [MapW-1:0]  map_i, map_q;
  logic signed [MapW-1:0]  prev_i_q, prev_q_q;
  logic signed [MapW-1:0]  cur_i_q, cur_q_q, old_i_q, old_q_q;
  logic signed [ProdW-1:0] p_ii, p_qq, p_qi, p_iq;
  logic signed [ProdW:0]   dot_w, cross_w;
  logic signed [ProdW-1:0] dot_q, cross_q;
  logic [ProdW-1:0]        dot_neg, cross_neg;
  logic [MagW-1:0]         ax, ay;
  logic [MagW-1:0]         num_q, den_q;
  fmqd_side_t              side_q;
  logic [2:0]              vld_q;

  // 2*b - 255 is odd, so its low bit is one and the upper bits are b offset by 128.
  assign map_i = {~i_sample_i[7], i_sample_i[6:0], 1'b1};
  assign map_q = {~q_sample_i[7], q_sample_i[6:0], 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_i_q <= '0;
      prev_q_q <= '0;
      vld_q    <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], in_valid_i};
      if (in_valid_i) begin
        prev_i_q <= map_i;
        prev_q_q <= map_q;
      end
    end
  end

  assign p_ii    = cur_i_q * old_i_q;
  assign p_qq    = cur_q_q * old_q_q;
  assign p_qi    = cur_q_q * old_i_q;
  assign p_iq    = cur_i_q * old_q_q;
  assign dot_w   = (ProdW+1)'(p_ii) + (ProdW+1)'(p_qq);
  assign cross_w = (ProdW+1)'(p_qi) - (ProdW+1)'(p_iq);

  assign dot_neg   = -dot_q;
  assign cross_neg = -cross_q;
  assign ax = dot_q[ProdW-1]   ? dot_neg[MagW-1:0]   : dot_q[MagW-1:0];
  assign ay = cross_q[ProdW-1] ? cross_neg[MagW-1:0] : cross_q[MagW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cur_i_q      <= map_i;
      cur_q_q      <= map_q;
      old_i_q      <= prev_i_q;
      old_q_q      <= prev_q_q;
      dot_q        <= dot_w[ProdW-1:0];
      cross_q      <= cross_w[ProdW-1:0];
      num_q        <= (ax < ay) ? ax : ay;
      den_q        <= (ax < ay) ? ay : ax;
      side_q.zero  <= (ax == '0) && (ay == '0);
      side_q.swap  <= ax < ay;
      side_q.x_neg <= dot_q[ProdW-1];
      side_q.y_neg <= cross_q[ProdW-1];
      side_q.y_pos <= !cross_q[ProdW-1] && (cross_q != '0);
    end
  end

  assign out_valid_o = vld_q[2];
  assign num_o       = num_q;
  assign den_o       = den_q;
  assign side_o      = side_q;

  a_num_le_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !side_q.zero |-> (num_q <= den_q) && (den_q != '0))
    else $error("octant reduction produced a ratio above one");

endmodule

// ----- hw/rtl/fmqd_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, giving the
// Q0.16 ratio floor(num * 65536 / den) for num <= den. Depends on fmqd_pkg.
module fmqd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [16:0]              num_i,
  input  logic [16:0]              den_i,
  input  fmqd_pkg::fmqd_side_t     side_i,
  output logic                     out_valid_o,
  output logic [16:0]              quot_o,
  output fmqd_pkg::fmqd_side_t     side_o
);
  import fmqd_pkg::*;

  localparam int unsigned Stages = QuotW;

  logic [Stages-1:0] vld_q;
  logic [MagW-1:0]   rem_q  [Stages];
  logic [MagW-1:0]   den_q  [Stages];
  logic [QuotW-1:0]  quot_q [Stages];
  fmqd_side_t        side_q [Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [MagW:0]    trial;
    logic [MagW:0]    diff;
    logic             ge;
    logic [MagW-1:0]  den_in;
    logic [QuotW-1:0] quot_in;
    fmqd_side_t       side_in;

    // The first stage yields the integer bit, which is set only when num equals den.
    if (k == 0) begin : g_head
      assign trial   = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign trial   = {rem_q[k-1], 1'b0};
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign diff = trial - {1'b0, den_in};
    assign ge   = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[MagW-1:0] : trial[MagW-1:0];
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[QuotW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  assign quot_o      = quot_q[Stages-1];
  assign side_o      = side_q[Stages-1];

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Stages-1] && !side_q[Stages-1].zero |->
      !quot_q[Stages-1][QuotW-1] || (quot_q[Stages-1][QuotW-2:0] == '0))
    else $error("ratio exceeds one");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Stages-1] && !side_q[Stages-1].zero |->
      rem_q[Stages-1] < den_q[Stages-1])
    else $error("divider remainder not below divisor");

endmodule

// ----- hw/rtl/fmqd_atan.sv -----
// Arctangent unit: squares the ratio, runs the five-term odd polynomial one
// Horner step per stage, restores the octant and applies the saturating gain.
// Depends on fmqd_pkg.
module fmqd_atan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [16:0]              ratio_i,
  input  fmqd_pkg::fmqd_side_t     side_i,
  input  logic [15:0]              gain_i,
  output logic                     out_valid_o,
  output logic signed [15:0]       mpx_o
);
  import fmqd_pkg::*;

  localparam int unsigned HornerN = 4;
  localparam int unsigned AccW    = 18;
  localparam int unsigned AngW    = 16;
  localparam int unsigned TW      = 12;
  localparam int unsigned MulW    = AngW + GainW + 1;
  localparam int unsigned Depth   = HornerN + 5;

  localparam logic signed [AccW-1:0] AccInit = 18'sd1365;
  localparam logic signed [AccW-1:0] HornerCoef [HornerN] =
    '{-18'sd5579, 18'sd11806, -18'sd21647, 18'sd65527};
  localparam logic signed [AngW-1:0] Pi     = 16'sd12868;
  localparam logic signed [AngW-1:0] HalfPi = 16'sd6434;
  localparam logic signed [MpxW-1:0] MpxMax = 16'sd32767;
  localparam logic signed [MpxW-1:0] MpxMin = -16'sd32768;

  // c + trunc(acc * s / 65536), rounding toward zero.
  function automatic logic signed [AccW-1:0] horner_step(
    input logic signed [AccW-1:0] c,
    input logic signed [AccW-1:0] acc,
    input logic [QuotW-1:0]       s
  );
    logic signed [2*AccW-1:0] prod;
    logic signed [2*AccW-1:0] biased;
    prod   = acc * $signed({1'b0, s});
    biased = prod + (prod[2*AccW-1] ? 36'sd65535 : 36'sd0);
    return AccW'(c + $signed(biased[AccW+15:16]));
  endfunction

  logic [Depth-1:0]        vld_q;
  logic [2*QuotW-1:0]      msq;
  logic [QuotW-1:0]        m1_q, s1_q;
  fmqd_side_t              side1_q;
  logic signed [AccW-1:0]  acc_q  [HornerN];
  logic [QuotW-1:0]        mh_q   [HornerN];
  logic [QuotW-1:0]        sh_q   [HornerN];
  fmqd_side_t              sideh_q[HornerN];
  logic signed [2*AccW-1:0] poly;
  logic [TW-1:0]           t_q;
  fmqd_side_t              sidet_q;
  logic signed [AngW-1:0]  t_pos, t_sgn, ang_d, ang_q;
  logic signed [MulW-1:0]  mul_q, mul_biased;
  logic signed [MulW-13:0] scaled;
  logic signed [MpxW-1:0]  mpx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  assign msq = ratio_i * ratio_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= ratio_i;
      s1_q    <= msq[2*QuotW-2:QuotW-1];
      side1_q <= side_i;
      for (int k = 0; k < HornerN; k++) begin
        if (k == 0) begin
          acc_q[k]   <= horner_step(HornerCoef[k], AccInit, s1_q);
          mh_q[k]    <= m1_q;
          sh_q[k]    <= s1_q;
          sideh_q[k] <= side1_q;
        end else begin
          acc_q[k]   <= horner_step(HornerCoef[k], acc_q[k-1], sh_q[k-1]);
          mh_q[k]    <= mh_q[k-1];
          sh_q[k]    <= sh_q[k-1];
          sideh_q[k] <= sideh_q[k-1];
        end
      end
    end
  end

  // Q0.16 radians to Q3.12: a negative polynomial result clamps to zero.
  assign poly = $signed({1'b0, mh_q[HornerN-1]}) * acc_q[HornerN-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= poly[2*AccW-1] ? '0 : poly[TW+19:20];
      sidet_q <= sideh_q[HornerN-1];
    end
  end

  assign t_pos = AngW'($signed({1'b0, t_q}));
  assign t_sgn = (sidet_q.x_neg != sidet_q.y_neg) ? -t_pos : t_pos;

  always_comb begin
    if (sidet_q.zero) begin
      ang_d = '0;
    end else if (!sidet_q.swap) begin
      if (sidet_q.x_neg) begin
        ang_d = t_sgn + (sidet_q.y_neg ? -Pi : Pi);
      end else begin
        ang_d = t_sgn;
      end
    end else begin
      ang_d = (sidet_q.y_pos ? HalfPi : -HalfPi) - t_sgn;
    end
  end

  // Divide by 4096 toward zero, then clip to the 16-bit range.
  assign mul_biased = mul_q + (mul_q[MulW-1] ? 33'sd4095 : 33'sd0);
  assign scaled     = mul_biased[MulW-1:12];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
      mul_q <= ang_q * $signed({1'b0, gain_i});
      if (scaled > (MulW-12)'(MpxMax)) begin
        mpx_q <= MpxMax;
      end else if (scaled < (MulW-12)'(MpxMin)) begin
        mpx_q <= MpxMin;
      end else begin
        mpx_q <= scaled[MpxW-1:0];
      end
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign mpx_o       = mpx_q;

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Depth-3] |-> (ang_q <= Pi) && (ang_q >= -Pi))
    else $error("phase step outside plus or minus pi");

endmodule

// ----- hw/rtl/fmqd_skid.sv -----
// Output register with a skid slot. The pipeline advances only while the
// skid slot is empty, so the stall path back to the input is registered.
// Depends on fmqd_pkg.
module fmqd_skid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [15:0] in_data_i,
  output logic        pipe_en_o,
  output logic        out_valid_o,
  output logic [15:0] out_data_o,
  input  logic        out_ready_i
);
  import fmqd_pkg::*;

  logic            out_valid_q, skid_valid_q;
  logic [MpxW-1:0] out_data_q, skid_data_q;

  assign pipe_en_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_ready_i) begin
      skid_valid_q <= in_valid_i;
    end else begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_data_q <= skid_data_q;
      end
    end else if (out_valid_q && !out_ready_i) begin
      skid_data_q <= in_data_i;
    end else begin
      out_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a beat while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid slot filled without a stalled output");

endmodule

// ----- bench/fmqd_mpx_checker.sv -----
// Scoreboard for the FM quadrature discriminator: predicts every MPX sample.
// Watches the IQ, MPX and gain channels of the block. Depends on fmqd_pkg.
// Reports each mismatch and hands the error count and open expectations upward.
module fmqd_mpx_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       iq_valid_i,
  input  logic                       iq_ready_i,
  input  logic [15:0]                iq_data_i,      // [7:0] i_sample, [15:8] q_sample
  input  logic                       mpx_valid_i,
  input  logic                       mpx_ready_i,
  input  logic [15:0]                mpx_data_i,     // [15:0] mpx_sample
  input  logic                       gain_valid_i,
  input  logic                       gain_ready_i,
  input  logic [fmqd_pkg::GainW-1:0] gain_data_i,
  output int                         outstanding_o,
  output int                         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fmqd_pkg::*;

  localparam longint PiQ12     = 12868;
  localparam longint HalfPiQ12 = 6434;
  // Odd polynomial coefficients of the arctangent, Q0.16.
  localparam longint AtanC1 = 65527;
  localparam longint AtanC3 = -21647;
  localparam longint AtanC5 = 11806;
  localparam longint AtanC7 = -5579;
  localparam longint AtanC9 = 1365;

  logic [GainW-1:0]          gain_q;
  int                        last_i;
  int                        last_q;
  int                        err_count;
  int                        new_i;
  int                        new_q;
  logic signed [MpxW-1:0]    mpx_expected[$];
  logic signed [MpxW-1:0]    want;

  assign errors_o = err_count;

  // Arctangent of num/den with num <= den, den > 0, as a Q3.12 magnitude.
  function automatic longint atan_q12(longint num, longint den);
    longint ratio, sq, acc, p;
    ratio = (num * 65536) / den;
    sq    = (ratio * ratio) / 65536;
    acc   = AtanC9;
    acc   = AtanC7 + (acc * sq) / 65536;
    acc   = AtanC5 + (acc * sq) / 65536;
    acc   = AtanC3 + (acc * sq) / 65536;
    acc   = AtanC1 + (acc * sq) / 65536;
    p     = (ratio * acc) / 65536;
    if (p < 0) p = 0;
    return p / 16;
  endfunction

  function automatic longint phase_angle_q12(longint cross_v, longint dot_v);
    fmqd_side_t side;
    longint     ax, ay, t;
    ax = (dot_v < 0) ? -dot_v : dot_v;
    ay = (cross_v < 0) ? -cross_v : cross_v;
    side.zero  = (ax == 0) && (ay == 0);
    side.swap  = ay > ax;
    side.x_neg = dot_v < 0;
    side.y_neg = cross_v < 0;
    side.y_pos = cross_v > 0;
    if (side.zero) return 0;
    if (!side.swap) begin
      t = atan_q12(ay, ax);
      if (side.y_neg != side.x_neg) t = -t;
      if (side.x_neg) t += side.y_neg ? -PiQ12 : PiQ12;
      return t;
    end
    t = atan_q12(ax, ay);
    if (side.x_neg != side.y_neg) t = -t;
    return (side.y_pos ? HalfPiQ12 : -HalfPiQ12) - t;
  endfunction

  function automatic logic signed [MpxW-1:0] predict_mpx(int vi, int vq, int pvi, int pvq,
                                                          logic [GainW-1:0] gain);
    longint dot_v, cross_v, scaled;
    dot_v   = longint'(vi) * pvi + longint'(vq) * pvq;
    cross_v = longint'(vq) * pvi - longint'(vi) * pvq;
    scaled  = (phase_angle_q12(cross_v, dot_v) * longint'(gain)) / 4096;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    return scaled[MpxW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q        <= GainReset;
      last_i        <= 0;
      last_q        <= 0;
      err_count     = 0;
      mpx_expected.delete();
      outstanding_o <= 0;
    end else begin
      if (mpx_valid_i && mpx_ready_i) begin
        if (mpx_expected.size() == 0) begin
          $display("%0t: MPX beat with nothing expected: expected none, actual %0d",
                   $time, $signed(mpx_data_i));
          err_count++;
        end else begin
          want = mpx_expected.pop_front();
          if (mpx_data_i !== want) begin
            $display("%0t: mpx_sample mismatch: expected %0d, actual %0d",
                     $time, want, $signed(mpx_data_i));
            err_count++;
          end
        end
      end
      if (gain_valid_i && gain_ready_i) gain_q <= gain_data_i;
      if (iq_valid_i && iq_ready_i) begin
        new_i = 2 * int'(iq_data_i[7:0]) - 255;
        new_q = 2 * int'(iq_data_i[15:8]) - 255;
        mpx_expected.push_back(predict_mpx(new_i, new_q, last_i, last_q, gain_q));
        last_i <= new_i;
        last_q <= new_q;
      end
      outstanding_o <= mpx_expected.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Top of the FM quadrature discriminator bench: clock, reset and stimulus.
// Drives IQ beats, gain writes and output back-pressure; the verdict comes from
// the fmqd_mpx_checker instance. Depends on fmqd_pkg and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmqd_pkg::*;

  localparam int DrainSlack = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [15:0]        m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [GainW-1:0]   cfg_data_i;
  int                 outstanding;
  int                 errors;
  bit                 steady_run;
  real                phase;
  real                phase_step;
  real                amplitude;

  fm_quadrature_discriminator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  fmqd_mpx_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .iq_valid_i    (s_axis_tvalid),
    .iq_ready_i    (s_axis_tready),
    .iq_data_i     (s_axis_tdata),
    .mpx_valid_i   (m_axis_tvalid),
    .mpx_ready_i   (m_axis_tready),
    .mpx_data_i    (m_axis_tdata),
    .gain_valid_i  (cfg_valid_i),
    .gain_ready_i  (cfg_ready_o),
    .gain_data_i   (cfg_data_i),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [7:0] to_byte(real x);
    int v;
    v = $rtoi(x + 0.5);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_iq(input logic [7:0] i_byte, input logic [7:0] q_byte);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q_byte, i_byte};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gap = steady_run ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every MPX sample in flight has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GainW-1:0] gain);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Most beats follow a rotating phasor, the way a tuned carrier looks; the rest
  // are uniform noise and full-scale corner bytes.
  task automatic send_random_items(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        amplitude  = real'($urandom_range(1, 127));
        phase_step = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 3.14;
        if ($urandom_range(0, 1) == 0) phase_step = phase_step / 16.0;
      end
      if (n % 50 == 0) steady_run = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        phase = phase + phase_step;
        if (phase > 6.283185) phase = phase - 6.283185;
        if (phase < 0.0) phase = phase + 6.283185;
        send_iq(to_byte(127.5 + amplitude * $cos(phase)),
                to_byte(127.5 + amplitude * $sin(phase)));
      end else if (r < 88) begin
        send_iq(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_iq($urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 1) + 127),
                $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 1) + 127));
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
    steady_run = 1'b0;
  endtask

  // Output back-pressure: ready runs, long calm stretches now and then.
  initial begin
    int run;
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    steady_run    = 1'b0;
    phase         = 0.0;
    phase_step    = 0.1;
    amplitude     = 100.0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset gain. The first pair meets a zero history, so
    // both products are zero. Then opposite, perpendicular and unit-size pairs
    // hit the octant borders and the exact half-turn in both directions.
    send_iq(8'd200, 8'd50);
    send_iq(8'd255, 8'd255);
    send_iq(8'd0,   8'd0);
    send_iq(8'd0,   8'd255);
    send_iq(8'd255, 8'd0);
    send_iq(8'd255, 8'd255);
    send_iq(8'd128, 8'd127);
    send_iq(8'd127, 8'd128);
    send_iq(8'd128, 8'd128);
    send_iq(8'd255, 8'd128);
    send_iq(8'd255, 8'd127);
    send_iq(8'd127, 8'd127);
    send_iq(8'd0,   8'd127);
    send_iq(8'd127, 8'd0);
    send_iq(8'd255, 8'd254);
    send_iq(8'd254, 8'd255);
    send_iq(8'd1,   8'd0);
    send_iq(8'd0,   8'd1);

    write_gain(16'd0);
    send_random_items(60);
    write_gain(16'hFFFF);
    send_random_items(100);
    write_gain(16'd1);
    send_random_items(60);
    write_gain(16'd4096);
    send_random_items(120);
    repeat (3) begin
      write_gain(16'($urandom_range(0, 65535)));
      send_random_items(100);
    end
    write_gain(GainReset);
    send_random_items(160);

    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
